>>> hdl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types and constants for the set statistics and duplicate detector.
// ----------------------------------------------------------------------------
`default_nettype none
package ssd_pkg;
    localparam int VAL_W         = 32;
    localparam int SUM_W         = 38;
    localparam int DVD_W         = SUM_W + 8;
    localparam int RES_W         = 48;
    localparam int KIND_W        = 3;
    localparam int MAX_ITEMS_DEF = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_SUM  = 3'd0,
        KIND_MEAN = 3'd1,
        KIND_MAX  = 3'd2,
        KIND_MIN  = 3'd3,
        KIND_DUP  = 3'd4,
        KIND_NONE = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DIVGO,
        ST_DIV,
        ST_SUM,
        ST_MEAN,
        ST_MAX,
        ST_MIN,
        ST_SCAN
    } state_t;
endpackage
`default_nettype wire

>>> hdl/set_statistics_and_duplicates_top.sv
// ----------------------------------------------------------------------------
// set_statistics_and_duplicates_top
// Set statistics (sum, Q8 mean, max, min) and duplicate report.
// ----------------------------------------------------------------------------
// Values load one per cycle into a row of MAX_ITEMS cells while sum, min and
// max are updated. After the item flagged last the input stalls: a start state
// launches a serial divider for the mean, then four statistics items go out,
// then the cell row shifts toward its head one cell per cycle while the output
// is not stalled, each cell comparing itself to the head for the duplicate
// scan. The input stays stalled until the report's final item goes out.
`default_nettype none
module set_statistics_and_duplicates_top #(
    parameter int MAX_ITEMS = ssd_pkg::MAX_ITEMS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        value_valid,
    output logic                             value_stall,
    input  wire logic [ssd_pkg::VAL_W-1:0]   value,
    input  wire logic                        last,
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output logic      [ssd_pkg::KIND_W-1:0]  kind,
    output logic      [ssd_pkg::RES_W-1:0]   result_value,
    output logic                             dropped,
    output logic                             final_res
);
    import ssd_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [VAL_W-1:0]  min_reg;
    logic [VAL_W-1:0]  max_reg;
    logic              ovf_reg;
    logic [VAL_W-1:0]  pend_reg;
    logic              pend_valid_reg;

    logic              out_valid_reg;
    kind_t             kind_reg;
    logic [RES_W-1:0]  res_reg;
    logic              drop_reg;
    logic              final_reg;

    logic              accept;
    logic              store_ok;
    logic              out_free;
    logic              emit;
    kind_t             emit_kind;
    logic [RES_W-1:0]  emit_value;
    logic              emit_final;
    logic              shift_en;
    logic              div_start;
    logic              div_done;
    logic [RES_W-1:0]  mean_q;
    logic              end_report;

    logic [VAL_W-1:0]     cell_value [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] cell_valid;
    logic [MAX_ITEMS-1:0] cell_match;
    logic                 any_match;

    assign value_stall = (state_reg != ST_LOAD);
    assign accept      = value_valid && !value_stall;
    assign store_ok    = (count_reg < CNT_W'(MAX_ITEMS));
    assign out_free    = !out_valid_reg || !result_stall;
    assign any_match   = |cell_match[MAX_ITEMS-1:1];
    assign shift_en    = (state_reg == ST_SCAN) && out_free && cell_valid[0];
    assign end_report  = (state_reg == ST_SCAN) && out_free && !cell_valid[0];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++)
        begin : g_cell
            logic [VAL_W-1:0] nv;
            logic             nvld;
            if (gi == MAX_ITEMS - 1)
            begin : g_tail
                assign nv   = '0;
                assign nvld = 1'b0;
            end
            else
            begin : g_mid
                assign nv   = cell_value[gi+1];
                assign nvld = cell_valid[gi+1];
            end
            ssd_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .load_en    (accept && store_ok && (count_reg == CNT_W'(gi))),
                .load_value (value),
                .shift_en   (shift_en),
                .next_value (nv),
                .next_valid (nvld),
                .head_value (cell_value[0]),
                .value_out  (cell_value[gi]),
                .valid_out  (cell_valid[gi]),
                .match      (cell_match[gi])
            );
        end
    endgenerate

    ssd_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({sum_reg, 8'b0}),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (mean_q)
    );

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        emit       = 1'b0;
        emit_kind  = KIND_SUM;
        emit_value = '0;
        emit_final = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept && last)
                begin
                    state_next = ST_DIVGO;
                end
            end
            ST_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_kind  = KIND_SUM;
                    emit_value = RES_W'($signed(sum_reg));
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_kind  = KIND_MEAN;
                    emit_value = mean_q;
                    state_next = ST_MAX;
                end
            end
            ST_MAX:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_kind  = KIND_MAX;
                    emit_value = RES_W'($signed(max_reg));
                    state_next = ST_MIN;
                end
            end
            ST_MIN:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_kind  = KIND_MIN;
                    emit_value = RES_W'($signed(min_reg));
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (shift_en)
                begin
                    if (any_match && pend_valid_reg)
                    begin
                        emit       = 1'b1;
                        emit_kind  = KIND_DUP;
                        emit_value = RES_W'($signed(pend_reg));
                    end
                end
                else if (end_report)
                begin
                    emit       = 1'b1;
                    emit_final = 1'b1;
                    emit_kind  = pend_valid_reg ? KIND_DUP : KIND_NONE;
                    emit_value = pend_valid_reg ? RES_W'($signed(pend_reg)) : '0;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            sum_reg        <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                if (store_ok)
                begin
                    count_reg <= count_reg + 1'b1;
                    sum_reg   <= sum_reg + SUM_W'($signed(value));
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (shift_en && any_match)
            begin
                pend_valid_reg <= 1'b1;
            end
            if (end_report)
            begin
                count_reg      <= '0;
                sum_reg        <= '0;
                ovf_reg        <= 1'b0;
                pend_valid_reg <= 1'b0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && store_ok)
        begin
            if (count_reg == '0 || $signed(value) < $signed(min_reg))
            begin
                min_reg <= value;
            end
            if (count_reg == '0 || $signed(value) > $signed(max_reg))
            begin
                max_reg <= value;
            end
        end
        if (shift_en && any_match)
        begin
            pend_reg <= cell_value[0];
        end
        if (emit)
        begin
            kind_reg  <= emit_kind;
            res_reg   <= emit_value;
            drop_reg  <= ovf_reg;
            final_reg <= emit_final;
        end
    end

    assign result_valid = out_valid_reg;
    assign kind         = kind_reg;
    assign result_value = res_reg;
    assign dropped      = drop_reg;
    assign final_res    = final_reg;
endmodule
`default_nettype wire

>>> hdl/ssd_cell.sv
// ----------------------------------------------------------------------------
// ssd_cell
// One store cell: holds a value, shifts toward the head, compares to head.
// ----------------------------------------------------------------------------
`default_nettype none
module ssd_cell (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     load_en,
    input  wire logic [ssd_pkg::VAL_W-1:0] load_value,
    input  wire logic                     shift_en,
    input  wire logic [ssd_pkg::VAL_W-1:0] next_value,
    input  wire logic                     next_valid,
    input  wire logic [ssd_pkg::VAL_W-1:0] head_value,
    output logic      [ssd_pkg::VAL_W-1:0] value_out,
    output logic                          valid_out,
    output logic                          match
);
    import ssd_pkg::*;

    logic [VAL_W-1:0] value_reg;
    logic             valid_reg;

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            value_reg <= load_value;
        end
        else if (shift_en)
        begin
            value_reg <= next_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_en)
        begin
            valid_reg <= 1'b1;
        end
        else if (shift_en)
        begin
            valid_reg <= next_valid;
        end
    end

    assign value_out = value_reg;
    assign valid_out = valid_reg;
    assign match     = valid_reg && (value_reg == head_value);
endmodule
`default_nettype wire

>>> hdl/ssd_div.sv
// ----------------------------------------------------------------------------
// ssd_div
// Serial signed divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
`default_nettype none
module ssd_div #(
    parameter int CNT_W = 6
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [ssd_pkg::DVD_W-1:0] dividend,
    input  wire logic [CNT_W-1:0]          divisor,
    output logic                           done,
    output logic      [ssd_pkg::RES_W-1:0] quotient
);
    import ssd_pkg::*;

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  mag_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W:0]    trial;
    logic              fits;
    logic [RES_W-1:0]  q_ext;

    assign trial = {rem_reg, mag_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= dividend[DVD_W-1] ? (~dividend + 1'b1) : dividend;
            neg_reg <= dividend[DVD_W-1];
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            mag_reg <= {mag_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? CNT_W'(trial - {1'b0, dvs_reg}) : CNT_W'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign q_ext    = RES_W'(mag_reg);
    assign quotient = (dvs_reg == '0) ? '0 : (neg_reg ? (~q_ext + 1'b1) : q_ext);
    assign done     = done_reg;
endmodule
`default_nettype wire

>>> hdl/ssd_checker.sv
// ----------------------------------------------------------------------------
// ssd_checker
// Port-level checks for the set statistics block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module ssd_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       value_stall,
    input wire logic                       result_valid,
    input wire logic                       result_stall,
    input wire logic [ssd_pkg::KIND_W-1:0] kind,
    input wire logic [ssd_pkg::RES_W-1:0]  result_value,
    input wire logic                       final_res
);
    import ssd_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(kind)
            && $stable(result_value))
        else $error("stalled result changed");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> kind <= KIND_NONE)
        else $error("bad kind code");

    a_final: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && final_res |-> kind == KIND_DUP || kind == KIND_NONE)
        else $error("report ends on a statistics item");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_SUM |-> value_stall)
        else $error("input open during report");

    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_NONE |-> final_res && result_value == '0)
        else $error("bad no-duplicate item");
endmodule

bind set_statistics_and_duplicates_top ssd_checker u_ssd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .value_stall  (value_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .result_value (result_value),
    .final_res    (final_res)
);
`default_nettype wire
